// ----- rtl/icr_pkg.sv -----
package icr_pkg;

  // datapath widths
  localparam int unsigned PosWidth   = 16;
  localparam int unsigned DepthWidth = 8;
  localparam int unsigned SpanWidth  = 16;
  localparam int unsigned SymWidth   = 8;

  typedef logic [PosWidth-1:0]   pos_t;
  typedef logic [DepthWidth-1:0] depth_t;
  typedef logic [SpanWidth-1:0]  span_t;
  typedef logic [SymWidth-1:0]   sym_t;

  localparam pos_t   PosMax   = {PosWidth{1'b1}};
  localparam depth_t DepthMax = {DepthWidth{1'b1}};

  // length of the keyword plus its terminator
  localparam pos_t KeywordLen = pos_t'(3);

  // operation codes
  localparam logic OpSymbol  = 1'b0;
  localparam logic OpRestart = 1'b1;

  // characters of interest
  localparam sym_t ChI      = 8'h69;
  localparam sym_t ChF      = 8'h66;
  localparam sym_t ChSpace  = 8'h20;
  localparam sym_t ChLf     = 8'h0A;
  localparam sym_t ChLParen = 8'h28;
  localparam sym_t ChRParen = 8'h29;
  localparam sym_t ChLBrace = 8'h7B;
  localparam sym_t ChRBrace = 8'h7D;
  localparam sym_t ChColon  = 8'h3A;

  typedef enum logic [1:0] {
    StNotFound = 2'd0,
    StKeyword  = 2'd1,
    StReady    = 2'd2,
    StError    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ErrNone        = 3'd0,
    ErrCloseParen  = 3'd1,
    ErrJunkKeyword = 3'd2,
    ErrTrueClose   = 3'd3,
    ErrJunkCond    = 3'd4,
    ErrFalseClose  = 3'd5,
    ErrJunkFalse   = 3'd6,
    ErrDepth       = 3'd7
  } err_e;

  typedef enum logic [1:0] {
    BrNone = 2'd0,
    BrTrue = 2'd1,
    BrBoth = 2'd2
  } branch_e;

  // one result word
  typedef struct packed {
    status_e status;
    err_e    error;
    branch_e branch;
    span_t   cond_start;
    span_t   cond_end;
    span_t   true_start;
    span_t   true_end;
    span_t   false_start;
    span_t   false_end;
  } res_t;

endpackage

// ----- rtl/icr_scan.sv -----
module icr_scan (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic            op_i,
  input  icr_pkg::sym_t   sym_i,
  output icr_pkg::res_t   res_o
);

  typedef enum logic [2:0] {
    ScKeyword = 3'd0,
    ScCond    = 3'd1,
    ScTrue    = 3'd2,
    ScFalse   = 3'd3,
    ScWeave   = 3'd4
  } scope_e;

  typedef enum logic [1:0] {
    BmPassive = 2'd0,
    BmOpen    = 2'd1,
    BmClosed  = 2'd2
  } body_e;

  // all-zero value is the reset state
  typedef struct packed {
    icr_pkg::pos_t    pos;
    icr_pkg::pos_t    wstart;
    logic             active;
    scope_e           scope;
    logic [15:0]      ftc;
    logic             hmode;
    icr_pkg::depth_t  hdepth;
    body_e            tmode;
    body_e            fmode;
    icr_pkg::depth_t  tdepth;
    icr_pkg::depth_t  fdepth;
    icr_pkg::pos_t    cs;
    icr_pkg::pos_t    ce;
    icr_pkg::pos_t    ts;
    icr_pkg::pos_t    te;
    icr_pkg::pos_t    fs;
    icr_pkg::pos_t    fe;
    icr_pkg::branch_e branch;
    icr_pkg::status_e status;
    icr_pkg::err_e    error;
  } state_t;

  state_t st_q, st_d;

  always_comb begin
    icr_pkg::pos_t end_p;
    icr_pkg::pos_t cur_p;
    logic          ws_c;
    logic          done;
    body_e         tm;
    body_e         fm;

    st_d  = st_q;
    end_p = (st_q.pos != icr_pkg::PosMax) ? st_q.pos + icr_pkg::pos_t'(1) : icr_pkg::PosMax;
    cur_p = end_p - icr_pkg::pos_t'(1);
    ws_c  = (sym_i == icr_pkg::ChSpace) || (sym_i == icr_pkg::ChLf);
    done  = 1'b0;
    tm    = st_q.tmode;
    fm    = st_q.fmode;

    if (step_i) begin
      if (op_i == icr_pkg::OpRestart) begin
        st_d = '0;
      end else if (st_q.error == icr_pkg::ErrNone) begin
        st_d.pos = end_p;
        // leading whitespace of a word
        if (!st_q.active) begin
          if (ws_c) begin
            if (st_q.wstart != icr_pkg::PosMax) begin
              st_d.wstart = st_q.wstart + icr_pkg::pos_t'(1);
            end
          end else begin
            st_d.active = 1'b1;
          end
        end

        if (st_d.active) begin
          // keyword capture and match
          if (st_d.scope == ScKeyword) begin
            if (cur_p >= st_d.wstart) begin
              if (cur_p == st_d.wstart) begin
                st_d.ftc[7:0] = sym_i;
              end else if (cur_p - st_d.wstart == icr_pkg::pos_t'(1)) begin
                st_d.ftc[15:8] = sym_i;
              end
            end
            if ((ws_c || sym_i == icr_pkg::ChLParen) && st_d.wstart <= end_p &&
                end_p - st_d.wstart == icr_pkg::KeywordLen &&
                st_d.ftc[7:0] == icr_pkg::ChI && st_d.ftc[15:8] == icr_pkg::ChF) begin
              st_d.wstart = end_p;
              st_d.active = 1'b0;
              st_d.scope  = ScCond;
              st_d.status = icr_pkg::StKeyword;
            end
          end

          case (st_d.scope)
            ScCond: begin
              if (sym_i == icr_pkg::ChLParen) begin
                if (!st_d.hmode) begin
                  st_d.cs    = end_p;
                  st_d.hmode = 1'b1;
                end
                if (st_d.hdepth == icr_pkg::DepthMax) begin
                  st_d.error  = icr_pkg::ErrDepth;
                  st_d.status = icr_pkg::StError;
                end else begin
                  st_d.hdepth = st_d.hdepth + icr_pkg::depth_t'(1);
                end
              end else if (sym_i == icr_pkg::ChRParen) begin
                if (!st_d.hmode) begin
                  st_d.error  = icr_pkg::ErrCloseParen;
                  st_d.status = icr_pkg::StError;
                end else begin
                  if (st_d.hdepth != '0) begin
                    st_d.hdepth = st_d.hdepth - icr_pkg::depth_t'(1);
                  end
                  if (st_d.hdepth == '0) begin
                    st_d.ce     = cur_p;
                    st_d.wstart = end_p;
                    st_d.active = 1'b0;
                    st_d.scope  = ScTrue;
                  end
                end
              end else if (!ws_c && !st_d.hmode) begin
                st_d.error  = icr_pkg::ErrJunkKeyword;
                st_d.status = icr_pkg::StError;
              end
            end
            ScTrue: begin
              if (sym_i == icr_pkg::ChLBrace) begin
                if (tm == BmPassive) begin
                  st_d.ts = cur_p;
                  tm      = BmOpen;
                end
                if (tm == BmOpen) begin
                  if (st_d.tdepth == icr_pkg::DepthMax) begin
                    st_d.tmode  = tm;
                    st_d.error  = icr_pkg::ErrDepth;
                    st_d.status = icr_pkg::StError;
                    done        = 1'b1;
                  end else begin
                    st_d.tdepth = st_d.tdepth + icr_pkg::depth_t'(1);
                  end
                end
              end
              if (sym_i == icr_pkg::ChRBrace) begin
                if (tm == BmPassive) begin
                  st_d.error  = icr_pkg::ErrTrueClose;
                  st_d.status = icr_pkg::StError;
                  done        = 1'b1;
                end else if (tm == BmOpen) begin
                  if (st_d.tdepth != '0) begin
                    st_d.tdepth = st_d.tdepth - icr_pkg::depth_t'(1);
                  end
                  if (st_d.tdepth == '0) begin
                    st_d.te    = end_p;
                    st_d.tmode = BmClosed;
                    done       = 1'b1;
                  end
                end
              end
              if (!done) begin
                st_d.tmode = tm;
                if (!ws_c) begin
                  if (tm == BmPassive) begin
                    st_d.error  = icr_pkg::ErrJunkCond;
                    st_d.status = icr_pkg::StError;
                  end else if (tm == BmClosed) begin
                    // first non-whitespace character after the true body picks the form
                    if (sym_i == icr_pkg::ChColon) begin
                      st_d.branch = icr_pkg::BrBoth;
                      st_d.scope  = ScFalse;
                    end else begin
                      st_d.branch = icr_pkg::BrTrue;
                      st_d.scope  = ScWeave;
                      st_d.status = icr_pkg::StReady;
                    end
                    st_d.wstart = end_p;
                    st_d.active = 1'b0;
                  end
                end
              end
            end
            ScFalse: begin
              if (sym_i == icr_pkg::ChLBrace) begin
                if (fm == BmPassive) begin
                  st_d.fs    = cur_p;
                  fm         = BmOpen;
                  st_d.fmode = fm;
                end
                if (st_d.fdepth == icr_pkg::DepthMax) begin
                  st_d.error  = icr_pkg::ErrDepth;
                  st_d.status = icr_pkg::StError;
                end else begin
                  st_d.fdepth = st_d.fdepth + icr_pkg::depth_t'(1);
                end
              end else if (sym_i == icr_pkg::ChRBrace) begin
                if (fm == BmPassive) begin
                  st_d.error  = icr_pkg::ErrFalseClose;
                  st_d.status = icr_pkg::StError;
                end else begin
                  if (st_d.fdepth != '0) begin
                    st_d.fdepth = st_d.fdepth - icr_pkg::depth_t'(1);
                  end
                  if (st_d.fdepth == '0) begin
                    st_d.fe     = end_p;
                    st_d.scope  = ScWeave;
                    st_d.status = icr_pkg::StReady;
                    st_d.wstart = end_p;
                    st_d.active = 1'b0;
                  end
                end
              end else if (!ws_c && fm == BmPassive) begin
                st_d.error  = icr_pkg::ErrJunkFalse;
                st_d.status = icr_pkg::StError;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    res_o.status      = st_d.status;
    res_o.error       = st_d.error;
    res_o.branch      = st_d.branch;
    res_o.cond_start  = icr_pkg::span_t'(st_d.cs);
    res_o.cond_end    = icr_pkg::span_t'(st_d.ce);
    res_o.true_start  = icr_pkg::span_t'(st_d.ts);
    res_o.true_end    = icr_pkg::span_t'(st_d.te);
    res_o.false_start = icr_pkg::span_t'(st_d.fs);
    res_o.false_end   = icr_pkg::span_t'(st_d.fe);
  end

endmodule

// ----- rtl/if_construct_recognizer.sv -----
// if-construct recognizer: takes one source character word per cycle unless the result channel
// stalls, and tracks the form "if (cond) {true} [: {false}]", skipping leading spaces and line
// feeds, counting nested parentheses and braces, and returns one result word per input word
// with status, error kind, branch kind and the six span positions as they stand after that
// character. A restart word clears everything. Errors are sticky until a restart. Throughput
// is one word per cycle with no bubbles unless the result channel stalls; an accepted word
// passes from the input register through the single-pass scanner update into the output register.
// The output register lets a new word be taken while a finished result still waits.
module if_construct_recognizer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  operation_i,
  input  logic [7:0]            symbol_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic [2:0]            error_kind_o,
  output logic [1:0]            branch_kind_o,
  output logic [15:0]           condition_start_o,
  output logic [15:0]           condition_end_o,
  output logic [15:0]           true_start_o,
  output logic [15:0]           true_end_o,
  output logic [15:0]           false_start_o,
  output logic [15:0]           false_end_o
);

  // input register
  logic          in_vld_q;
  logic          op_q;
  icr_pkg::sym_t sym_q;

  // output register
  logic          out_vld_q;
  icr_pkg::res_t res_q;

  logic          advance;
  logic          step;
  icr_pkg::res_t res;

  // the output register frees up when empty or when its word is taken
  assign advance    = !out_vld_q || out_ready_i;
  // a held word moves through the scanner only when its result has a place to go
  assign step       = in_vld_q && advance;
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q  <= operation_i;
      sym_q <= symbol_i;
    end
  end

  // scanner state and its single-pass update
  icr_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .op_i   (op_q),
    .sym_i  (sym_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign status_o          = res_q.status;
  assign error_kind_o      = res_q.error;
  assign branch_kind_o     = res_q.branch;
  assign condition_start_o = res_q.cond_start;
  assign condition_end_o   = res_q.cond_end;
  assign true_start_o      = res_q.true_start;
  assign true_end_o        = res_q.true_end;
  assign false_start_o     = res_q.false_start;
  assign false_end_o       = res_q.false_end;

endmodule

// ----- rtl/icr_checker.sv -----
module icr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        operation_i,
  input logic [7:0]  symbol_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [2:0]  error_kind_o,
  input logic [1:0]  branch_kind_o,
  input logic [15:0] condition_start_o,
  input logic [15:0] condition_end_o,
  input logic [15:0] true_start_o,
  input logic [15:0] true_end_o,
  input logic [15:0] false_start_o,
  input logic [15:0] false_end_o
);

  // error status and error kind always agree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == icr_pkg::StError) == (error_kind_o != icr_pkg::ErrNone)))
    else $error("status and error kind disagree");

  // a finished construct always has a branch kind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == icr_pkg::StReady) |-> (branch_kind_o != icr_pkg::BrNone))
    else $error("ready without branch kind");

  // nothing recognised yet means no spans and no branch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == icr_pkg::StNotFound) |->
      (condition_start_o == '0 && condition_end_o == '0 && true_start_o == '0 &&
       true_end_o == '0 && false_start_o == '0 && false_end_o == '0 &&
       branch_kind_o == icr_pkg::BrNone))
    else $error("spans set before keyword");

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(status_o) && $stable(error_kind_o) && $stable(true_end_o)))
    else $error("stalled result word changed");

endmodule

bind if_construct_recognizer icr_checker u_icr_checker (.*);
